[rtl/tmff_pkg.sv]
// Shared types and constants for the tile map flood fill block.
// No dependencies; the design modules and the testbench import this package.
`timescale 1ns / 1ps
package tmff_pkg;
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 64;
  localparam int LAYER_COUNT = 4;
  localparam int STACK_DEPTH = 32768;

  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int LAYER_W = 2;
  localparam int SIZE_W  = 7;
  localparam int TILE_W  = 25;
  localparam int ADDR_W  = LAYER_W + ROW_W + COL_W;
  localparam int STK_W   = ROW_W + COL_W;
  localparam int SP_W    = $clog2(STACK_DEPTH);
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_FILL  = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SAME = 2'd1;
  localparam logic [1:0] ST_OOR  = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [2:0] K_WRITE = 3'd0;
  localparam logic [2:0] K_READ  = 3'd1;
  localparam logic [2:0] K_FILL  = 3'd2;
  localparam logic [2:0] K_NOP   = 3'd3;
  localparam logic [2:0] K_OOR   = 3'd4;

  localparam logic [0:0] REG_WIDTH  = 1'd0;
  localparam logic [0:0] REG_HEIGHT = 1'd1;

  typedef struct packed {
    logic [2:0]         kind;
    logic [COL_W-1:0]   x;
    logic [ROW_W-1:0]   y;
    logic [LAYER_W-1:0] layer;
    logic [TILE_W-1:0]  word;
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
  } cmd_t;
endpackage

[rtl/tmff_in_if.sv]
// Input request channel: valid/ready plus the request fields.
// Depends on nothing.
`timescale 1ns / 1ps
interface tmff_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  cell_x;
  logic [5:0]  cell_y;
  logic [1:0]  layer;
  logic        in_present;
  logic [7:0]  in_sheet;
  logic [15:0] in_index;
  modport source (output valid, mode, cell_x, cell_y, layer, in_present, in_sheet,
                  in_index, input ready);
  modport sink (input valid, mode, cell_x, cell_y, layer, in_present, in_sheet,
                in_index, output ready);
endinterface

[rtl/tmff_out_if.sv]
// Result channel: valid/ready plus status and read tile.
// Depends on nothing.
`timescale 1ns / 1ps
interface tmff_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        out_present;
  logic [7:0]  out_sheet;
  logic [15:0] out_index;
  modport source (output valid, status, out_present, out_sheet, out_index, input ready);
  modport sink (input valid, status, out_present, out_sheet, out_index, output ready);
endinterface

[rtl/tmff_cfg_if.sv]
// Configuration write channel: valid/ready, register index and data.
// Depends on nothing.
`timescale 1ns / 1ps
interface tmff_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [6:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tile_map_flood_fill.sv]
// Tile map flood fill: write, read or four-connected fill of a layered tile map.
// Write, out-of-range and unused mode answer from idle, a read after its tile read. An unskipped fill
// pops a stack entry, reads and compares its tile, and tests four neighbours of each recoloured cell.
// One request is worked at a time; the two-entry queue takes requests while a fill runs.
// Reset: synchronous; a clearing pass over all 16384 tile addresses empties the map, no request taken.
`timescale 1ns / 1ps
module tile_map_flood_fill import tmff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tmff_in_if.sink     in_ch,
  tmff_out_if.source  out_ch,
  tmff_cfg_if.sink    cfg
);
  logic cmd_valid;
  logic cmd_ready;
  logic busy;
  cmd_t cmd;

  tmff_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  tmff_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .busy      (busy),
    .out_ch    (out_ch)
  );
endmodule

[rtl/tmff_front.sv]
// Front end: size registers, request classification and a two-entry command queue.
// Depends on tmff_pkg, tmff_in_if and tmff_cfg_if.
`timescale 1ns / 1ps
module tmff_front import tmff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  tmff_in_if.sink     in_ch,
  tmff_cfg_if.sink    cfg,
  input  logic        busy,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);
  logic [SIZE_W-1:0] map_width;
  logic [SIZE_W-1:0] map_height;
  logic [SIZE_W-1:0] w;
  logic [SIZE_W-1:0] h;
  cmd_t              q [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  cmd_t              new_cmd;
  logic              push;
  logic              pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= SIZE_W'(MAX_COLUMNS);
      map_height <= SIZE_W'(MAX_ROWS);
    end else if (cfg.valid) begin
      if (cfg.index == REG_WIDTH) map_width <= cfg.data;
      if (cfg.index == REG_HEIGHT) map_height <= cfg.data;
    end
  end

  // zero counts as one, oversize saturates
  always_comb begin
    w = map_width;
    h = map_height;
    if (map_width == '0) w = SIZE_W'(1);
    else if (32'(map_width) > MAX_COLUMNS) w = SIZE_W'(MAX_COLUMNS);
    if (map_height == '0) h = SIZE_W'(1);
    else if (32'(map_height) > MAX_ROWS) h = SIZE_W'(MAX_ROWS);
  end

  always_comb begin
    new_cmd.x     = in_ch.cell_x;
    new_cmd.y     = in_ch.cell_y;
    new_cmd.layer = in_ch.layer;
    new_cmd.w     = w;
    new_cmd.h     = h;
    new_cmd.word  = in_ch.in_present ? {1'b1, in_ch.in_sheet, in_ch.in_index} : '0;
    if (in_ch.mode != MODE_WRITE && in_ch.mode != MODE_READ && in_ch.mode != MODE_FILL)
      new_cmd.kind = K_NOP;
    else if ({1'b0, in_ch.cell_x} >= w || {1'b0, in_ch.cell_y} >= h ||
             32'(in_ch.layer) >= LAYER_COUNT)
      new_cmd.kind = K_OOR;
    else if (in_ch.mode == MODE_WRITE) new_cmd.kind = K_WRITE;
    else if (in_ch.mode == MODE_READ) new_cmd.kind = K_READ;
    else new_cmd.kind = K_FILL;
  end

  assign in_ch.ready = (fill != 2'd2) && !busy;
  assign push      = in_ch.valid && in_ch.ready;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= new_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/tmff_engine.sv]
// Back end: tile memory with clearing pass, walk stack and the sequencer for writes, reads and fills.
// Depends on tmff_pkg and tmff_out_if.
`timescale 1ns / 1ps
module tmff_engine import tmff_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd,
  output logic        busy,
  tmff_out_if.source  out_ch
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_FT    = 4'd3;
  localparam logic [3:0] S_POP   = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_CMP   = 4'd6;
  localparam logic [3:0] S_PUSH  = 4'd7;

  logic [TILE_W-1:0] tiles [2**ADDR_W];
  logic [STK_W-1:0]  stk [STACK_DEPTH];

  logic [3:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  cmd_t              cur;
  logic [TILE_W-1:0] target;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [1:0]        nb;
  logic [COL_W-1:0]  cx;
  logic [ROW_W-1:0]  cy;

  logic              t_we;
  logic [ADDR_W-1:0] t_waddr;
  logic [TILE_W-1:0] t_wdata;
  logic [ADDR_W-1:0] t_raddr;
  logic [TILE_W-1:0] t_rdata;
  logic              s_we;
  logic [SP_W-1:0]   s_waddr;
  logic [STK_W-1:0]  s_wdata;
  logic [SP_W-1:0]   s_raddr;
  logic [STK_W-1:0]  s_rdata;
  logic              nb_ok;
  logic [COL_W-1:0]  nx;
  logic [ROW_W-1:0]  ny;
  logic [CNT_W-1:0]  count_m1;

  always_ff @(posedge clk) begin
    if (t_we) tiles[t_waddr] <= t_wdata;
    t_rdata <= tiles[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) stk[s_waddr] <= s_wdata;
    s_rdata <= stk[s_raddr];
  end

  assign busy      = (state == S_CLEAR);
  assign cmd_ready = (state == S_IDLE) && !out_ch.valid;
  assign count_m1  = count - CNT_W'(1);

  // neighbour under test: left, right, up, down
  always_comb begin
    nx = cx;
    ny = cy;
    nb_ok = 1'b0;
    case (nb)
      2'd0: begin nx = cx - COL_W'(1); nb_ok = (cx != '0); end
      2'd1: begin nx = cx + COL_W'(1); nb_ok = ({1'b0, cx} + SIZE_W'(1)) < cur.w; end
      2'd2: begin ny = cy - ROW_W'(1); nb_ok = (cy != '0); end
      2'd3: begin ny = cy + ROW_W'(1); nb_ok = ({1'b0, cy} + SIZE_W'(1)) < cur.h; end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    t_we    = 1'b0;
    t_waddr = {cur.layer, cy, cx};
    t_wdata = cur.word;
    t_raddr = {cmd.layer, cmd.y, cmd.x};
    s_we    = 1'b0;
    s_waddr = count[SP_W-1:0];
    s_wdata = {ny, nx};
    s_raddr = count_m1[SP_W-1:0];
    case (state)
      S_CLEAR: begin
        t_we    = 1'b1;
        t_waddr = clr_addr;
        t_wdata = '0;
      end
      S_IDLE: begin
        t_we    = cmd_valid && cmd_ready && cmd.kind == K_WRITE;
        t_waddr = {cmd.layer, cmd.y, cmd.x};
        t_wdata = cmd.word;
      end
      S_FT: begin
        s_we    = (t_rdata != cur.word);
        s_waddr = '0;
        s_wdata = {cur.y, cur.x};
      end
      S_SRD: t_raddr = {cur.layer, s_rdata};
      S_CMP: t_we = (t_rdata == target);
      S_PUSH: s_we = nb_ok && (32'(count) < STACK_DEPTH);
      default: t_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      count        <= '0;
      ovf          <= 1'b0;
      nb           <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur <= cmd;
            cx  <= cmd.x;
            cy  <= cmd.y;
            out_ch.out_present <= 1'b0;
            out_ch.out_sheet   <= '0;
            out_ch.out_index   <= '0;
            case (cmd.kind)
              K_READ: state <= S_RD;
              K_FILL: state <= S_FT;
              K_OOR: begin
                out_ch.status <= ST_OOR;
                out_ch.valid  <= 1'b1;
              end
              default: begin
                out_ch.status <= ST_DONE;
                out_ch.valid  <= 1'b1;
              end
            endcase
          end
        end
        S_RD: begin
          {out_ch.out_present, out_ch.out_sheet, out_ch.out_index} <= t_rdata;
          out_ch.status <= ST_DONE;
          out_ch.valid  <= 1'b1;
          state         <= S_IDLE;
        end
        S_FT: begin
          target <= t_rdata;
          if (t_rdata == cur.word) begin
            out_ch.status <= ST_SAME;
            out_ch.valid  <= 1'b1;
            state         <= S_IDLE;
          end else begin
            count <= CNT_W'(1);
            ovf   <= 1'b0;
            state <= S_POP;
          end
        end
        S_POP: begin
          if (count == '0) begin
            out_ch.status <= ovf ? ST_OVF : ST_DONE;
            out_ch.valid  <= 1'b1;
            state         <= S_IDLE;
          end else begin
            count <= count_m1;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          {cy, cx} <= s_rdata;
          state    <= S_CMP;
        end
        S_CMP: begin
          nb    <= '0;
          state <= (t_rdata == target) ? S_PUSH : S_POP;
        end
        S_PUSH: begin
          if (nb_ok) begin
            if (32'(count) < STACK_DEPTH) count <= count + CNT_W'(1);
            else ovf <= 1'b1;
          end
          nb <= nb + 2'd1;
          if (nb == 2'd3) state <= S_POP;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= STACK_DEPTH) else $error("stack count beyond depth");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> count == '0) else $error("stack not empty between requests");
  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !cmd_ready && !out_ch.valid) else $error("request taken while clearing");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && state != S_RD)
    else $error("result dropped");
`endif
endmodule

[bench/tile_map_flood_fill_tb.sv]
// Testbench for tile_map_flood_fill: random and directed write, read and fill requests,
// checked against a behavioural model of the layered tile map and its flood fill.
// Depends on tmff_pkg, the three channel interfaces and tile_map_flood_fill.
`timescale 1ns / 1ps
module tile_map_flood_fill_tb;
  import tmff_pkg::*;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [1:0]  layer;
    logic        in_present;
    logic [7:0]  in_sheet;
    logic [15:0] in_index;
  } tile_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        out_present;
    logic [7:0]  out_sheet;
    logic [15:0] out_index;
  } tile_rsp_t;

  localparam int CYCLE_LIMIT = 40000000;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic clk;
  logic rst;
  tmff_in_if  in_ch();
  tmff_out_if out_ch();
  tmff_cfg_if cfg();

  tile_map_flood_fill uut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg));

  logic [TILE_W-1:0] map_model [LAYER_COUNT*MAX_ROWS*MAX_COLUMNS];
  logic [STK_W-1:0]  walk_model [STACK_DEPTH];
  logic [SIZE_W-1:0] width_reg, height_reg;

  tile_req_t pending_reqs[$];
  tile_rsp_t expected_rsps[$];
  int  fail_count;
  int  cycle_count;
  bit  tx_enable;
  bit  calm;
  int  sizes [6][2] = '{'{64, 64}, '{1, 1}, '{0, 127}, '{5, 3}, '{8, 8}, '{64, 2}};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int clamp_size(logic [SIZE_W-1:0] r, int lim);
    if (r == 0) return 1;
    return (r > lim) ? lim : int'(r);
  endfunction

  function automatic int map_addr(int l, int x, int y);
    return (l * MAX_ROWS + y) * MAX_COLUMNS + x;
  endfunction

  function automatic tile_rsp_t predict_tile(tile_req_t r);
    tile_rsp_t rsp;
    int w, h, a, sp, x, y;
    logic [TILE_W-1:0] word, target;
    bit ovf;
    rsp = '0;
    w = clamp_size(width_reg, MAX_COLUMNS);
    h = clamp_size(height_reg, MAX_ROWS);
    word = r.in_present ? {1'b1, r.in_sheet, r.in_index} : '0;
    if (r.mode == MODE_UNUSED) return rsp;
    if (r.cell_x >= w || r.cell_y >= h || r.layer >= LAYER_COUNT) begin
      rsp.status = ST_OOR;
      return rsp;
    end
    a = map_addr(r.layer, r.cell_x, r.cell_y);
    if (r.mode == MODE_WRITE) begin
      map_model[a] = word;
    end else if (r.mode == MODE_READ) begin
      {rsp.out_present, rsp.out_sheet, rsp.out_index} = map_model[a];
    end else begin
      target = map_model[a];
      if (target == word) begin
        rsp.status = ST_SAME;
        return rsp;
      end
      ovf = 0;
      walk_model[0] = {r.cell_y, r.cell_x};
      sp = 1;
      while (sp > 0) begin
        sp--;
        x = walk_model[sp][COL_W-1:0];
        y = walk_model[sp][STK_W-1:COL_W];
        if (x >= w || y >= h) continue;
        a = map_addr(r.layer, x, y);
        if (map_model[a] != target) continue;
        map_model[a] = word;
        // drop pushes onto a full stack
        if (x > 0) begin
          if (sp < STACK_DEPTH) begin walk_model[sp] = {6'(y), 6'(x-1)}; sp++; end
          else ovf = 1;
        end
        if (x + 1 < w) begin
          if (sp < STACK_DEPTH) begin walk_model[sp] = {6'(y), 6'(x+1)}; sp++; end
          else ovf = 1;
        end
        if (y > 0) begin
          if (sp < STACK_DEPTH) begin walk_model[sp] = {6'(y-1), 6'(x)}; sp++; end
          else ovf = 1;
        end
        if (y + 1 < h) begin
          if (sp < STACK_DEPTH) begin walk_model[sp] = {6'(y+1), 6'(x)}; sp++; end
          else ovf = 1;
        end
      end
      if (ovf) rsp.status = ST_OVF;
    end
    return rsp;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (tx_enable && pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        tile_req_t r;
        r = pending_reqs.pop_front();
        expected_rsps.insert(expected_rsps.size(), predict_tile(r));
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= r.mode;
        in_ch.cell_x     <= r.cell_x;
        in_ch.cell_y     <= r.cell_y;
        in_ch.layer      <= r.layer;
        in_ch.in_present <= r.in_present;
        in_ch.in_sheet   <= r.in_sheet;
        in_ch.in_index   <= r.in_index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          tile_rsp_t e;
          e = expected_rsps.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.out_present !== e.out_present) begin
            $error("out_present expected %0d actual %0d", e.out_present, out_ch.out_present);
            fail_count++;
          end
          if (out_ch.out_sheet !== e.out_sheet) begin
            $error("out_sheet expected %0d actual %0d", e.out_sheet, out_ch.out_sheet);
            fail_count++;
          end
          if (out_ch.out_index !== e.out_index) begin
            $error("out_index expected %0d actual %0d", e.out_index, out_ch.out_index);
            fail_count++;
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 16);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  task automatic add_req(logic [1:0] m, int x, int y, int l, bit p, int s, int i);
    tile_req_t r;
    r.mode = m; r.cell_x = 6'(x); r.cell_y = 6'(y); r.layer = 2'(l);
    r.in_present = p; r.in_sheet = 8'(s); r.in_index = 16'(i);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic random_req(int w, int h);
    int m;
    m = $urandom_range(99);
    // keep most accesses inside the map and most tile values among a few
    add_req(m < 40 ? MODE_WRITE : m < 70 ? MODE_READ : m < 94 ? MODE_FILL : MODE_UNUSED,
            ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(w - 1),
            ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(h - 1),
            $urandom_range(3), $urandom_range(1),
            ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(1),
            ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1));
  endtask

  task automatic drain_and_idle();
    wait (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !in_ch.valid);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val; else height_reg = val;
  endtask

  initial begin
    foreach (map_model[k]) map_model[k] = '0;
    width_reg = 7'd64; height_reg = 7'd64;
    fail_count = 0; cycle_count = 0; tx_enable = 0; calm = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0; in_ch.mode = '0; in_ch.cell_x = '0; in_ch.cell_y = '0;
    in_ch.layer = '0; in_ch.in_present = 0; in_ch.in_sheet = '0; in_ch.in_index = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = REG_WIDTH; cfg.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, every mode, empty write, same-tile and full-map fill
    add_req(MODE_READ, 63, 63, 3, 0, 0, 0);
    add_req(MODE_WRITE, 0, 0, 0, 1, 255, 65535);
    add_req(MODE_READ, 0, 0, 0, 0, 0, 0);
    add_req(MODE_WRITE, 63, 63, 3, 0, 255, 65535);
    add_req(MODE_READ, 63, 63, 3, 1, 0, 0);
    add_req(MODE_FILL, 5, 5, 1, 0, 7, 7);
    add_req(MODE_FILL, 10, 10, 2, 1, 3, 4);
    add_req(MODE_READ, 63, 0, 2, 0, 0, 0);
    add_req(MODE_FILL, 0, 0, 0, 1, 255, 65535);
    add_req(MODE_UNUSED, 1, 2, 1, 1, 9, 9);
    add_req(MODE_WRITE, 1, 0, 0, 1, 0, 0);
    add_req(MODE_READ, 1, 0, 0, 0, 0, 0);
    tx_enable = 1;
    drain_and_idle();

    // size registers out of range and small maps, with out-of-range cells
    foreach (sizes[s]) begin
      write_reg(REG_WIDTH, 7'(sizes[s][0]));
      write_reg(REG_HEIGHT, 7'(sizes[s][1]));
      add_req(MODE_WRITE, 63, 63, 0, 1, 1, 1);
      add_req(MODE_READ, 4, 2, 0, 0, 0, 0);
      add_req(MODE_FILL, 0, 0, 0, 1, 2, 2);
      calm = (s == 2);
      repeat (10) begin
        random_req(clamp_size(width_reg, MAX_COLUMNS), clamp_size(height_reg, MAX_ROWS));
      end
      // hold the sender until everything is back
      drain_and_idle();
    end
    calm = 0;
    write_reg(REG_WIDTH, 7'd64);
    write_reg(REG_HEIGHT, 7'd64);
    repeat (10) random_req(64, 64);
    drain_and_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/tmff_pkg.sv
rtl/tmff_in_if.sv
rtl/tmff_out_if.sv
rtl/tmff_cfg_if.sv
rtl/tmff_front.sv
rtl/tmff_engine.sv
rtl/tile_map_flood_fill.sv
bench/tile_map_flood_fill_tb.sv
